// File: sv/rgfr_pkg.sv
// Package for read_group_flag_router: payload structs, codes and the
// controller/datapath command and status structs. No dependencies.
package rgfr_pkg;

  localparam int ResLimit = 16;
  localparam int IdxW     = 4;

  typedef struct packed {
    logic        is_paired;
    logic        is_secondary;
    logic        is_supplementary;
    logic        is_first_mate;
    logic        is_second_mate;
    logic        is_mapped;
    logic        is_reverse;
    logic        is_proper;
    logic [31:0] ref_id;
    logic        last_in_group;
  } in_item_t;

  typedef struct packed {
    logic [3:0] record_index;
    logic [2:0] destination;
    logic [3:0] error_code;
    logic       last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    DEST_SINGLE     = 3'd0,
    DEST_ORPHAN     = 3'd1,
    DEST_SUPP       = 3'd2,
    DEST_UNMAPPED   = 3'd3,
    DEST_SPLIT      = 3'd4,
    DEST_SAMESTRAND = 3'd5,
    DEST_IMPROPER   = 3'd6,
    DEST_PROPER     = 3'd7
  } dest_t;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_PAIRED    = 4'd1,
    ERR_MATE_BITS = 4'd2,
    ERR_R1_FIRST  = 4'd3,
    ERR_R2_FIRST  = 4'd4,
    ERR_R1_MULTI  = 4'd5,
    ERR_R2_MULTI  = 4'd6,
    ERR_R1_MAP    = 4'd7,
    ERR_R1_UNMAP  = 4'd8,
    ERR_R2_MAP    = 4'd9,
    ERR_R2_UNMAP  = 4'd10,
    ERR_PROPER    = 4'd11,
    ERR_SECONDARY = 4'd12,
    ERR_OVERFLOW  = 4'd13
  } err_t;

  // controller -> datapath
  typedef struct packed {
    logic            store;      // write input record, bump count
    logic            clear;      // group done
    logic            scan_clr;   // reset scan summary
    logic            scan_en;    // fold rd data into summary
    logic [IdxW-1:0] rd_idx;     // store read address
    logic            load_out;   // capture out item
    out_item_t       out_item;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [4:0]  count;
    logic        overflow;
    logic [7:0]  rd_flags;       // flags of entry read last cycle
    logic [3:0]  err;            // summary verdict, valid after scan
    logic        unpaired;
    logic        orphan;
    logic [IdxW-1:0] r1_idx;
    logic [IdxW-1:0] r2_idx;
    logic [2:0]  pair_dest;
    logic        out_busy;
  } dp_sts_t;

  // flag byte positions, bit0 = paired
  localparam int FlPaired = 0;
  localparam int FlSec    = 1;
  localparam int FlSup    = 2;
  localparam int FlR1     = 3;
  localparam int FlR2     = 4;
  localparam int FlMap    = 5;
  localparam int FlRev    = 6;
  localparam int FlProp   = 7;

  function automatic logic [3:0] sort_key(input logic [7:0] f);
    sort_key = {~f[FlPaired], f[FlSec], f[FlSup], ~f[FlR1]};
  endfunction

endpackage

// File: sv/rgfr_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rgfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/rgfr_dp.sv
// Datapath: group store RAM, count, overflow, scan summary and output register.
// Depends on rgfr_pkg and rgfr_ram.
module rgfr_dp
  import rgfr_pkg::*;
#(
  parameter int Capacity = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output dp_sts_t   sts
);
  logic [4:0]  count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic [39:0] rdata;
  logic [IdxW-1:0] rd_idx_r;

  rgfr_ram #(.Width(40), .Depth(ResLimit)) u_store (
    .clk  (clk),
    .we   (cmd.store && (count_r < 5'(Capacity))),
    .waddr(count_r[IdxW-1:0]),
    .wdata({in_data.ref_id, in_data.is_proper, in_data.is_reverse, in_data.is_mapped,
            in_data.is_second_mate, in_data.is_first_mate, in_data.is_supplementary,
            in_data.is_secondary, in_data.is_paired}),
    .raddr(cmd.rd_idx),
    .rdata(rdata)
  );

  wire [7:0]  f   = rdata[7:0];
  wire [31:0] rid = rdata[39:8];

  // scan summary over sorted order (controller feeds entries sorted)
  logic            first_r;
  logic            p0_r;
  logic [3:0]      err_r;
  logic            n1_r, n2_r;        // set when the first-seen r1/r2 is sup or secondary
  logic [1:0]      m1_r, m2_r;        // non-sup counts, saturating at 2
  logic [7:0]      f1_r, f2_r;
  logic [31:0]     id1_r, id2_r;
  logic [IdxW-1:0] i1_r, i2_r;
  logic            any1_r, any2_r;
  logic            sec1_r, sec2_r, map1_r, map2_r;

  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.rd_idx;
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
    if (cmd.scan_clr) begin
      first_r <= 1'b1;
      err_r   <= ERR_OK;
      any1_r  <= 1'b0;
      any2_r  <= 1'b0;
      m1_r    <= '0;
      m2_r    <= '0;
    end else if (cmd.scan_en) begin
      first_r <= 1'b0;
      if (first_r) p0_r <= f[FlPaired];
      // paired mismatch outranks a mate bit error seen earlier
      if (!first_r && (f[FlPaired] != p0_r)) err_r <= ERR_PAIRED;
      else if ((err_r == ERR_OK) && f[FlPaired] && (f[FlR1] == f[FlR2]))
        err_r <= ERR_MATE_BITS;
      if (f[FlPaired] && (f[FlR1] != f[FlR2])) begin
        if (f[FlR1]) begin
          any1_r <= 1'b1;
          if (!any1_r && (f[FlSup] || f[FlSec])) n1_r <= 1'b1;
          else if (!any1_r) n1_r <= 1'b0;
          if (!f[FlSup]) begin
            if (m1_r == 2'd0) begin
              f1_r <= f; id1_r <= rid; i1_r <= rd_idx_r;
            end
            if (m1_r != 2'd2) m1_r <= m1_r + 2'd1;
          end
        end else begin
          any2_r <= 1'b1;
          if (!any2_r && (f[FlSup] || f[FlSec])) n2_r <= 1'b1;
          else if (!any2_r) n2_r <= 1'b0;
          if (!f[FlSup]) begin
            if (m2_r == 2'd0) begin
              f2_r <= f; id2_r <= rid; i2_r <= rd_idx_r;
            end
            if (m2_r != 2'd2) m2_r <= m2_r + 2'd1;
          end
        end
      end
      // later non-sup entries of a class: secondary and map checks, in order
      if (f[FlPaired] && (f[FlR1] != f[FlR2]) && !f[FlSup]) begin
        if (f[FlR1] && m1_r != 2'd0) begin
          if (!f[FlSec]) sec1_r <= 1'b1;
          if (f[FlMap] != f1_r[FlMap]) map1_r <= 1'b1;
        end
        if (f[FlR2] && m2_r != 2'd0) begin
          if (!f[FlSec]) sec2_r <= 1'b1;
          if (f[FlMap] != f2_r[FlMap]) map2_r <= 1'b1;
        end
      end
    end
    if (cmd.scan_clr) begin
      sec1_r <= 1'b0; sec2_r <= 1'b0; map1_r <= 1'b0; map2_r <= 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.store) begin
      if (count_r < 5'(Capacity)) count_nxt = count_r + 5'd1;
      else ovf_nxt = 1'b1;
    end
  end

  // verdict, priority in check order
  logic [3:0] verdict;
  logic [2:0] pdest;
  always_comb begin
    pdest = DEST_PROPER;
    if (!f1_r[FlMap] || !f2_r[FlMap]) pdest = DEST_UNMAPPED;
    else if (id1_r != id2_r) pdest = DEST_SPLIT;
    else if (f1_r[FlRev] == f2_r[FlRev]) pdest = DEST_SAMESTRAND;
    else if (!f1_r[FlProp]) pdest = DEST_IMPROPER;
    verdict = ERR_OK;
    if (err_r != ERR_OK) verdict = err_r;
    else if (!p0_r || !any1_r || !any2_r) verdict = ERR_OK;
    else if (n1_r) verdict = ERR_R1_FIRST;
    else if (n2_r) verdict = ERR_R2_FIRST;
    else if (sec1_r) verdict = ERR_R1_MULTI;
    else if (sec2_r) verdict = ERR_R2_MULTI;
    else if (map1_r) verdict = ERR_R1_MAP;
    else if (m1_r == 2'd2 && !f1_r[FlMap]) verdict = ERR_R1_UNMAP;
    else if (map2_r) verdict = ERR_R2_MAP;
    else if (m2_r == 2'd2 && !f2_r[FlMap]) verdict = ERR_R2_UNMAP;
    else if (m1_r == 2'd1 && m2_r == 2'd1) begin
      if (f1_r[FlMap] && f2_r[FlMap] && id1_r == id2_r && f1_r[FlRev] != f2_r[FlRev]
          && f1_r[FlProp] != f2_r[FlProp]) verdict = ERR_PROPER;
    end else verdict = ERR_SECONDARY;
  end

  logic      ov_r;
  out_item_t od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.load_out) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
    if (cmd.load_out) od_r <= cmd.out_item;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    sts.count     = count_r;
    sts.overflow  = ovf_r;
    sts.rd_flags  = f;
    sts.err       = verdict;
    sts.unpaired  = !p0_r;
    sts.orphan    = !any1_r || !any2_r;
    sts.r1_idx    = i1_r;
    sts.r2_idx    = i2_r;
    sts.pair_dest = pdest;
    sts.out_busy  = ov_r && !out_ready;
  end
endmodule

// File: sv/rgfr_ctrl.sv
// Controller: load, stable sort by key value (16 key passes), scan, emit, pair.
// Depends on rgfr_pkg.
module rgfr_ctrl
  import rgfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_sts_t  sts
);
  // Sorted order = for key 0..15, entries of that key in arrival order.
  // Each phase walks key x index; the RAM read is registered.
  // The supplementary pass takes all read 1 keys before the read 2 keys.
  typedef enum logic [2:0] {S_LOAD, S_SCAN, S_SCAN_END, S_EMIT, S_PAIR} state_t;
  typedef enum logic [1:0] {E_ALL, E_SUP} emode_t;

  state_t     state_r;
  logic [3:0] key_r;
  logic [4:0] idx_r;        // issued index, 0..count-1
  logic       pend_r;       // a read issued last cycle
  logic [3:0] pidx_r;
  logic [3:0] pkey_r;
  logic [4:0] emitted_r;
  emode_t     mode_r;
  logic       done_r;       // walk finished
  logic [1:0] pair_r;

  wire last_idx = (idx_r + 5'd1 >= sts.count);
  wire hit      = pend_r && (sort_key(sts.rd_flags) == pkey_r);
  wire is_sup   = sts.rd_flags[FlSup];
  wire [3:0] walk_key = (state_r == S_EMIT && mode_r == E_SUP) ? {key_r[2:0], key_r[3]}
                                                               : key_r;

  // walker stalls in EMIT while a read is pending and the output register is held
  wire stall = (state_r == S_EMIT) && pend_r && sts.out_busy;

  assign in_ready = (state_r == S_LOAD) && !sts.out_busy;

  always_comb begin
    cmd = '0;
    cmd.rd_idx = stall ? pidx_r : idx_r[3:0];
    cmd.store  = in_ready && in_valid;
    cmd.scan_en = (state_r == S_SCAN) && hit;
    if (state_r == S_LOAD && in_ready && in_valid && in_data.last_in_group)
      cmd.scan_clr = 1'b1;
    case (state_r)
      S_SCAN_END: begin
        if (sts.overflow || sts.err != ERR_OK) begin
          cmd.load_out = !sts.out_busy;
          cmd.out_item = '{4'd0, DEST_SINGLE,
                           sts.overflow ? ERR_OVERFLOW : sts.err, 1'b1};
          cmd.clear = cmd.load_out;
        end
      end
      S_EMIT: begin
        if (hit && !sts.out_busy) begin
          if (mode_r == E_ALL) begin
            cmd.load_out = 1'b1;
            cmd.out_item = '{pidx_r, sts.unpaired ? DEST_SINGLE : DEST_ORPHAN,
                             ERR_OK, emitted_r + 5'd1 == sts.count};
            cmd.clear = (emitted_r + 5'd1 == sts.count);
          end else if (is_sup && sts.rd_flags[FlPaired]) begin
            cmd.load_out = 1'b1;
            cmd.out_item = '{pidx_r, DEST_SUPP, ERR_OK, 1'b0};
          end
        end
      end
      S_PAIR: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_item = '{pair_r == 2'd0 ? sts.r1_idx : sts.r2_idx, sts.pair_dest,
                           ERR_OK, pair_r != 2'd0};
          cmd.clear = pair_r != 2'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pend_r  <= 1'b0;
      key_r   <= '0;
      idx_r   <= '0;
      done_r  <= 1'b0;
      emitted_r <= '0;
      mode_r  <= E_ALL;
      pair_r  <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_ready && in_valid && in_data.last_in_group) begin
            state_r <= S_SCAN;
            key_r <= '0; idx_r <= '0; pend_r <= 1'b0; done_r <= 1'b0;
          end
        end
        S_SCAN, S_EMIT: begin
          if (!stall) begin
            if (state_r == S_EMIT && cmd.load_out) emitted_r <= emitted_r + 5'd1;
            pend_r <= !done_r && (sts.count != 5'd0);
            pidx_r <= idx_r[3:0];
            pkey_r <= walk_key;
            if (!done_r) begin
              if (last_idx || sts.count == 5'd0) begin
                idx_r <= '0;
                key_r <= key_r + 4'd1;
                if (key_r == 4'd15 || sts.count == 5'd0) done_r <= 1'b1;
              end else idx_r <= idx_r + 5'd1;
            end else begin
              if (!pend_r) begin
                if (state_r == S_SCAN) state_r <= S_SCAN_END;
                else if (mode_r == E_SUP) begin state_r <= S_PAIR; pair_r <= '0; end
                else begin state_r <= S_LOAD; end
              end
            end
          end
        end
        S_SCAN_END: begin
          key_r <= '0; idx_r <= '0; pend_r <= 1'b0; done_r <= 1'b0;
          emitted_r <= '0;
          if (sts.overflow || sts.err != ERR_OK) begin
            if (!sts.out_busy) state_r <= S_LOAD;
          end else if (sts.count == 5'd0) begin
            state_r <= S_LOAD;
          end else begin
            mode_r <= (sts.unpaired || sts.orphan) ? E_ALL : E_SUP;
            state_r <= S_EMIT;
          end
        end
        S_PAIR: begin
          if (!sts.out_busy) begin
            pair_r <= pair_r + 2'd1;
            if (pair_r != 2'd0) state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// File: sv/read_group_flag_router.sv
// Top level of the read group flag router.
// Depends on rgfr_pkg, rgfr_ctrl, rgfr_dp.
//
//  channel | ports                        | carries
//  in      | in_valid in_ready in_data    | one record (flags, ref_id, last)
//  out     | out_valid out_ready out_data | one routed record or group error
//
// Records load one per cycle while in_ready is high (LOAD state, output not held).
// After the last record of n, the check scan walks 16 key passes of n reads,
// then come the verdict state, the routing walk and, for a paired group, the two
// pair results; an error ends the group after the verdict. Reset clears control
// only; the store needs no clearing. A held output stalls the walker and the input.
module read_group_flag_router
  import rgfr_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int Capacity = (MAX_GROUP < ResLimit) ? MAX_GROUP : ResLimit;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rgfr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(in_data),
    .in_ready(in_ready), .cmd(cmd), .sts(sts)
  );

  rgfr_dp #(.Capacity(Capacity)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data), .sts(sts)
  );
endmodule

// File: sv/rgfr_checker.sv
// Port-level checker for read_group_flag_router, bound to the top level.
// Depends on rgfr_pkg.
module rgfr_checker
  import rgfr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_OK |-> out_data.last_result)
    else $error("error transfer not last");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_OK |->
      out_data.record_index == 4'd0 && out_data.destination == DEST_SINGLE)
    else $error("error transfer payload");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out transfer dropped");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.error_code <= ERR_OVERFLOW)
    else $error("bad error code");
  a_group_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_in_group |=> !in_ready)
    else $error("input taken during group walk");
endmodule

bind read_group_flag_router rgfr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
